// File: design/sftl_pkg.sv
package sftl_pkg;

    // Port width of a vertex word and the part of it that identifies a vertex.
    localparam int VERTEX_W    = 64;
    localparam int VERTEX_BITS = 64;

    localparam logic [1:0] MODE_LIST  = 2'd0;
    localparam logic [1:0] MODE_STRIP = 2'd1;
    localparam logic [1:0] MODE_FAN   = 2'd2;

    // Number of result beats a loaded entry holds.
    localparam logic [1:0] BEATS_NONE = 2'd0;
    localparam logic [1:0] BEATS_LIST = 2'd1;
    localparam logic [1:0] BEATS_TRI  = 2'd3;

    typedef logic [VERTEX_BITS-1:0] t_vertex;

    typedef struct packed {
        logic       valid;
        logic [1:0] beats;
        t_vertex    v0;
        t_vertex    v1;
        t_vertex    v2;
    } t_tri;

    typedef struct packed {
        logic free;
    } t_buf_stat;

endpackage

// File: design/sftl_ifs.sv
interface sftl_cfg_if;
    import sftl_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] primitive_mode;
    modport source (output valid, output primitive_mode, input ready);
    modport sink   (input valid, input primitive_mode, output ready);
endinterface

interface sftl_in_if;
    import sftl_pkg::*;
    logic                valid;
    logic                ready;
    logic [VERTEX_W-1:0] vertex_word;
    logic                starts_primitive;
    modport source (output valid, output vertex_word, output starts_primitive, input ready);
    modport sink   (input valid, input vertex_word, input starts_primitive, output ready);
endinterface

interface sftl_out_if;
    import sftl_pkg::*;
    logic                valid;
    logic                ready;
    logic [VERTEX_W-1:0] out_vertex;
    logic [1:0]          corner;
    logic                run_last;
    modport source (output valid, output out_vertex, output corner, output run_last,
                    input ready);
    modport sink   (input valid, input out_vertex, input corner, input run_last,
                    output ready);
endinterface

// File: design/sftl_tri_buf.sv
module sftl_tri_buf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sftl_pkg::t_tri        i_load,
    output sftl_pkg::t_buf_stat   o_stat,
    sftl_out_if.source            o_out
);
    import sftl_pkg::*;

    t_vertex    r_v0, r_v1, r_v2;
    logic [1:0] r_left, n_left;
    logic [1:0] r_pos, n_pos;
    t_vertex    w_vertex;
    logic       w_fire;

    assign w_fire = o_out.valid && o_out.ready;

    // Free next cycle if empty or the final beat leaves now.
    assign o_stat.free = (r_left == 2'd0) || ((r_left == 2'd1) && o_out.ready);

    always_comb begin
        n_left = r_left;
        n_pos  = r_pos;
        if (i_load.valid) begin
            n_left = i_load.beats;
            n_pos  = 2'd0;
        end else if (w_fire) begin
            n_left = r_left - 2'd1;
            n_pos  = r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
            r_pos  <= 2'd0;
        end else begin
            r_left <= n_left;
            r_pos  <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.valid) begin
            r_v0 <= i_load.v0;
            r_v1 <= i_load.v1;
            r_v2 <= i_load.v2;
        end
    end

    always_comb begin
        case (r_pos)
            2'd1:    w_vertex = r_v1;
            2'd2:    w_vertex = r_v2;
            default: w_vertex = r_v0;
        endcase
    end

    assign o_out.valid      = (r_left != 2'd0);
    assign o_out.out_vertex = VERTEX_W'(w_vertex);
    assign o_out.corner     = r_pos;
    assign o_out.run_last   = (r_left == 2'd1);

endmodule

// File: design/strip_fan_to_triangle_list.sv
// A vertex passes the input register and then the triangle buffer on its way out.
// Throughput: one vertex per cycle in list mode or when it makes no triangle, while
// the result port takes each beat; after a vertex that makes a triangle, the next one
// waits until the one-beat-per-cycle result port drains the three-entry buffer.
// Reset (synchronous, active low): mode to list, held vertices, count and parity
// to zero, input and result registers empty.
module strip_fan_to_triangle_list (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sftl_cfg_if.sink    i_cfg,
    sftl_in_if.sink     i_in,
    sftl_out_if.source  o_out
);
    import sftl_pkg::*;

    logic [1:0] r_mode;

    logic       r_in_valid;
    t_vertex    r_in_vertex;
    logic       r_in_start;

    t_vertex    r_older, n_older;
    t_vertex    r_newer, n_newer;
    logic [1:0] r_seen, n_seen;
    logic       r_parity, n_parity;

    logic       w_advance;
    logic [1:0] w_cnt;
    logic       w_odd;
    logic       w_degen;
    t_tri       w_load;
    t_buf_stat  w_stat;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LIST;
        end else if (i_cfg.valid) begin
            r_mode <= i_cfg.primitive_mode;
        end
    end

    // Input register; moves on as soon as the triangle buffer can take its result.
    assign w_advance  = r_in_valid && w_stat.free;
    assign i_in.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_vertex <= i_in.vertex_word[VERTEX_BITS-1:0];
            r_in_start  <= i_in.starts_primitive;
        end
    end

    assign w_cnt = r_in_start ? 2'd0 : r_seen;
    assign w_odd = r_in_start ? 1'b0 : r_parity;

    always_comb begin
        w_load       = '0;
        w_load.valid = w_advance;
        w_load.beats = BEATS_NONE;
        w_load.v0    = r_in_vertex;
        w_load.v1    = r_in_vertex;
        w_load.v2    = r_in_vertex;
        n_older      = r_newer;
        n_newer      = r_in_vertex;
        unique case (r_mode)
            MODE_STRIP: begin
                w_load.v0 = r_older;
                w_load.v1 = w_odd ? r_in_vertex : r_newer;
                w_load.v2 = w_odd ? r_newer : r_in_vertex;
                if (w_cnt == 2'd2) begin
                    w_load.beats = BEATS_TRI;
                end
            end
            MODE_FAN: begin
                // older holds the fan center
                w_load.v0 = r_newer;
                w_load.v1 = r_in_vertex;
                w_load.v2 = r_older;
                if (w_cnt == 2'd2) begin
                    w_load.beats = BEATS_TRI;
                end
                n_older = (w_cnt == 2'd0) ? r_in_vertex : r_older;
            end
            default: begin
                w_load.beats = BEATS_LIST;
            end
        endcase
        w_degen = (w_load.v0 == w_load.v1) || (w_load.v0 == w_load.v2) ||
                  (w_load.v1 == w_load.v2);
        if (w_load.beats == BEATS_TRI && w_degen) begin
            w_load.beats = BEATS_NONE;
        end
        n_seen   = (w_cnt == 2'd2) ? w_cnt : w_cnt + 2'd1;
        n_parity = ~w_odd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older  <= '0;
            r_newer  <= '0;
            r_seen   <= 2'd0;
            r_parity <= 1'b0;
        end else if (w_advance) begin
            r_older  <= n_older;
            r_newer  <= n_newer;
            r_seen   <= n_seen;
            r_parity <= n_parity;
        end
    end

    sftl_tri_buf u_tri_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .o_stat  (w_stat),
        .o_out   (o_out)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load.valid |-> w_stat.free)
        else $error("triangle buffer loaded while beats remain");

    a_seen_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen != 2'd3)
        else $error("vertex count past saturation");

    a_corner_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.corner == 2'd2) |-> o_out.run_last)
        else $error("third corner not flagged as final beat");

    a_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_stat.free) |=> (r_in_valid && $stable(r_in_vertex)))
        else $error("input register lost a vertex while buffer busy");

endmodule

// File: sim/tb_strip_fan_to_triangle_list.sv
module tb_strip_fan_to_triangle_list;
    timeunit 1ns;
    timeprecision 1ps;

    import sftl_pkg::*;

    localparam logic [1:0] MODE_SPARE   = 2'd3;   // unused encoding, acts as list
    localparam logic [1:0] CORNER_LEAD  = 2'd0;
    localparam logic [1:0] CORNER_MID   = 2'd1;
    localparam logic [1:0] CORNER_TAIL  = 2'd2;
    localparam int         HOLD_CYCLES  = 200;
    localparam int         SETTLE       = 6;
    localparam int         STALL_LIMIT  = 1000;

    typedef struct {
        logic [VERTEX_W-1:0] vertex;
        logic [1:0]          corner;
        logic                last;
    } t_beat;

    logic i_clk;
    logic i_rst_n;

    sftl_cfg_if cfg_if();
    sftl_in_if  in_if();
    sftl_out_if out_if();

    strip_fan_to_triangle_list dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // assembly state mirrored from the block
    logic [1:0] cur_mode;
    t_vertex    held_old;
    t_vertex    held_new;
    int         run_count;
    logic       run_odd;

    t_beat pending_beats[$];

    int  mismatches        = 0;
    int  vertices_sent     = 0;
    int  beats_checked     = 0;
    int  triangles_dropped = 0;
    int  mode_writes       = 0;
    int  src_idle_pct      = 0;
    int  sink_idle_pct     = 0;
    bit  hold_req          = 0;
    int  holds_done        = 0;
    bit  offering          = 0;
    logic [VERTEX_W-1:0] recent[2];

    function automatic void push_beat(input t_vertex v, input logic [1:0] corner,
                                      input logic last);
        t_beat b;
        b.vertex = VERTEX_W'(v);
        b.corner = corner;
        b.last   = last;
        pending_beats.insert(pending_beats.size(), b);
    endfunction

    function automatic void push_triangle(input t_vertex a, input t_vertex b,
                                          input t_vertex c);
        if (a == b || a == c || b == c) begin
            triangles_dropped++;
        end else begin
            push_beat(a, CORNER_LEAD, 1'b0);
            push_beat(b, CORNER_MID, 1'b0);
            push_beat(c, CORNER_TAIL, 1'b1);
        end
    endfunction

    function automatic void assemble_vertex(input logic [VERTEX_W-1:0] word,
                                            input logic start);
        t_vertex v;
        logic    odd;
        v = word[VERTEX_BITS-1:0];
        if (start) begin
            run_count = 0;
            run_odd   = 1'b0;
        end
        odd = run_odd;
        case (cur_mode)
            MODE_STRIP: begin
                if (run_count >= 2) begin
                    // odd index swaps the last two to keep winding
                    if (odd) begin
                        push_triangle(held_old, v, held_new);
                    end else begin
                        push_triangle(held_old, held_new, v);
                    end
                end
                held_old = held_new;
                held_new = v;
            end
            MODE_FAN: begin
                // held_old is the fan center here
                if (run_count >= 2) begin
                    push_triangle(held_new, v, held_old);
                end
                if (run_count == 0) begin
                    held_old = v;
                end
                held_new = v;
            end
            default: begin
                push_beat(v, CORNER_LEAD, 1'b1);
                held_old = held_new;
                held_new = v;
            end
        endcase
        if (run_count < 2) begin
            run_count++;
        end
        run_odd = ~odd;
    endfunction

    function automatic logic [VERTEX_W-1:0] fresh_word();
        return {$urandom, $urandom};
    endfunction

    // mostly new vertices, now and then a repeat of a recent one
    function automatic logic [VERTEX_W-1:0] pick_vertex();
        if ($urandom_range(0, 99) < 15) begin
            return recent[$urandom_range(0, 1)];
        end
        return fresh_word();
    endfunction

    function automatic logic [1:0] pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return MODE_STRIP;
        end else if (r < 80) begin
            return MODE_FAN;
        end else if (r < 95) begin
            return MODE_LIST;
        end
        return MODE_SPARE;
    endfunction

    task automatic send_vertex(input logic [VERTEX_W-1:0] word, input logic start);
        int gap;
        if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
            gap = $urandom_range(1, 11);
            if (offering) begin
                in_if.valid <= 1'b0;
            end
            offering = 0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid            <= 1'b1;
        in_if.vertex_word      <= word;
        in_if.starts_primitive <= start;
        offering = 1;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        assemble_vertex(word, start);
        vertices_sent++;
        recent[1] = recent[0];
        recent[0] = word;
    endtask

    // sender stops, all results drain, then room for items still in flight
    task automatic wait_idle();
        if (offering) begin
            in_if.valid <= 1'b0;
        end
        offering = 0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [1:0] m);
        wait_idle();
        cfg_if.valid          <= 1'b1;
        cfg_if.primitive_mode <= m;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cur_mode = m;
        mode_writes++;
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_run(input int len);
        for (int k = 0; k < len; k++) begin
            send_vertex(pick_vertex(), k == 0);
        end
    endtask

    task automatic test_unflagged_start();
        set_mode(MODE_STRIP);
        send_vertex(64'd10, 1'b0);
        send_vertex(64'd20, 1'b0);
        send_vertex(64'd30, 1'b0);
        send_vertex(64'd40, 1'b0);
    endtask

    task automatic test_strip_extremes();
        send_vertex('0, 1'b1);
        send_vertex('1, 1'b0);
        send_vertex(64'hA5A5_A5A5_A5A5_A5A5, 1'b0);
        send_vertex('0, 1'b0);
        send_vertex(64'h5555_5555_5555_5555, 1'b0);
        send_vertex('0, 1'b0);                        // repeats vertex k-2: dropped
    endtask

    task automatic test_fan_shapes();
        set_mode(MODE_FAN);
        send_vertex(64'd100, 1'b1);
        send_vertex(64'd200, 1'b0);
        send_vertex(64'hFFFF_FFFF_0000_0300, 1'b0);
        send_vertex(64'd400, 1'b0);
        send_vertex(64'd100, 1'b0);                   // back to the center: dropped
        send_vertex(64'd7, 1'b1);                     // two-vertex fan, nothing out
        send_vertex(64'd8, 1'b0);
        send_vertex(64'd9, 1'b1);
    endtask

    task automatic test_spare_mode();
        set_mode(MODE_SPARE);
        send_vertex('1, 1'b1);
        send_vertex(64'h0123_4567_89AB_CDEF, 1'b0);
    endtask

    task automatic test_mode_switch();
        set_mode(MODE_STRIP);
        send_vertex(64'd1, 1'b1);
        send_vertex(64'd2, 1'b0);
        send_vertex(64'd3, 1'b0);
        set_mode(MODE_FAN);
        send_vertex(64'd4, 1'b0);
        set_mode(MODE_LIST);
        send_vertex(64'd5, 1'b0);
        set_mode(MODE_STRIP);
        send_vertex(64'd6, 1'b0);
    endtask

    // long result stall with the sender pushing: input side must back up
    task automatic test_result_holdoff();
        set_mode(MODE_STRIP);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_req = 1;
        send_vertex(fresh_word(), 1'b1);
        for (int k = 1; k < 24; k++) begin
            send_vertex(fresh_word(), 1'b0);
        end
        wait_idle();
    endtask

    task automatic test_random_runs(input int target);
        int runs;
        int len;
        while (vertices_sent < target) begin
            src_idle_pct  = $urandom_range(0, 2) * 15;
            sink_idle_pct = $urandom_range(0, 2) * 15;
            set_mode(pick_mode());
            runs = $urandom_range(2, 4);
            for (int r = 0; r < runs; r++) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
                for (int k = 0; k < len; k++) begin
                    if (k > 0 && $urandom_range(0, 99) < 5) begin
                        set_mode(pick_mode());
                    end
                    send_vertex(pick_vertex(), k == 0 || $urandom_range(0, 99) < 8);
                end
            end
        end
    endtask

    task automatic test_steady_tail();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        set_mode(MODE_FAN);
        send_run(12);
        set_mode(MODE_STRIP);
        send_run(10);
        send_run(8);
    endtask

    initial begin : result_ready_driver
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 0;
                hold_left = HOLD_CYCLES - 1;
                holds_done++;
                out_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (sink_idle_pct > 0 && $urandom_range(0, 99) < sink_idle_pct) begin
                stall_left = $urandom_range(1, 11) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    task automatic report_field(input string name, input logic [VERTEX_W-1:0] want,
                                input logic [VERTEX_W-1:0] got);
        mismatches++;
        $display("%0t: %s expected %h got %h", $time, name, want, got);
    endtask

    initial begin : result_checker
        t_beat want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                beats_checked++;
                if (pending_beats.size() == 0) begin
                    mismatches++;
                    $display("%0t: beat with nothing expected: expected none got %h/%0d/%b",
                             $time, out_if.out_vertex, out_if.corner, out_if.run_last);
                end else begin
                    want = pending_beats.pop_front();
                    if (out_if.out_vertex !== want.vertex) begin
                        report_field("out_vertex", want.vertex, out_if.out_vertex);
                    end
                    if (out_if.corner !== want.corner) begin
                        report_field("corner", VERTEX_W'(want.corner), VERTEX_W'(out_if.corner));
                    end
                    if (out_if.run_last !== want.last) begin
                        report_field("run_last", VERTEX_W'(want.last), VERTEX_W'(out_if.run_last));
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no beat accepted for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, pending_beats.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : run
        i_rst_n                <= 1'b0;
        cfg_if.valid           <= 1'b0;
        cfg_if.primitive_mode  <= MODE_LIST;
        in_if.valid            <= 1'b0;
        in_if.vertex_word      <= '0;
        in_if.starts_primitive <= 1'b0;
        cur_mode  = MODE_LIST;
        held_old  = '0;
        held_new  = '0;
        run_count = 0;
        run_odd   = 1'b0;
        recent[0] = '0;
        recent[1] = '1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_unflagged_start();
        test_strip_extremes();
        test_fan_shapes();
        test_spare_mode();
        test_mode_switch();
        test_result_holdoff();
        test_random_runs(240);
        test_steady_tail();
        wait_idle();

        $display("%0d vertices in %0d mode writes, %0d result beats checked, %0d degenerate",
                 vertices_sent, mode_writes, beats_checked, triangles_dropped);
        $display("triangles dropped; %0d long result stall(s) of %0d cycles",
                 holds_done, HOLD_CYCLES);
        if (mismatches == 0 && pending_beats.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
